@@ hdl/touch_contact_slot_tracker_assert.svh @@
// Assertion macros used by the checker file
`ifndef TOUCH_CONTACT_SLOT_TRACKER_ASSERT_SVH
`define TOUCH_CONTACT_SLOT_TRACKER_ASSERT_SVH
// Implication checked on every clock edge outside reset
`define TCST_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent
`define TCST_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

@@ hdl/tcst_pkg.sv @@
// ----------------------------------------------------------------------------
// tcst_pkg
// Types and constants of the touch contact slot tracker.
// ----------------------------------------------------------------------------
package tcst_pkg;

    localparam int MAX_SLOTS_DEF = 10;

    localparam logic [1:0] ACT_LIFT   = 2'd0;
    localparam logic [1:0] ACT_DOWN   = 2'd1;
    localparam logic [1:0] ACT_MOVE   = 2'd2;
    localparam logic [1:0] ACT_CANCEL = 2'd3;

    localparam int FL_INRANGE   = 0;
    localparam int FL_INCONTACT = 1;
    localparam int FL_DOWN      = 2;
    localparam int FL_UP        = 3;
    localparam int FL_UPDATE    = 4;
    localparam int FL_CANCELED  = 5;

    localparam int VM_PRESSURE = 0;
    localparam int VM_AREA     = 1;
    localparam int VM_ANGLE    = 2;

    localparam logic [10:0] PRESS_DEFAULT = 11'd512;
    localparam logic [10:0] PRESS_MAX     = 11'd1024;
    localparam logic [8:0]  ANGLE_LIMIT   = 9'd360;
    localparam logic [16:0] FRAC_MAX      = 17'd65536;

    typedef struct packed {
        logic [31:0] id;
        logic [5:0]  flags;
        logic [15:0] x;
        logic [15:0] y;
        logic [10:0] pressure;
        logic [2:0]  mask;
        logic [15:0] left;
        logic [15:0] top;
        logic [15:0] right;
        logic [15:0] bottom;
        logic [8:0]  angle;
    } slot_t;

    // f*65535 >> 16 == f - ceil(f/65536) for f <= 65536
    function automatic logic [15:0] scale_frac(input logic [16:0] f);
        logic [16:0] v;
        logic [16:0] r;
        v = (f > FRAC_MAX) ? FRAC_MAX : f;
        r = v - ((v != 17'd0) ? 17'd1 : 17'd0);
        return r[15:0];
    endfunction

endpackage

@@ hdl/touch_contact_slot_tracker.sv @@
// ----------------------------------------------------------------------------
// touch_contact_slot_tracker
// Touch contact slot table with frame output.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_stall takes one touch event item. Output channel
// out_valid/out_stall gives one contact item per slot of the frame, last on
// the final one. One compare unit walks the slot table one slot per cycle
// under a sequencer. Event: a search pass over the table, then the slot
// update. Then one frame item per cycle goes to the output register while
// the output is not stalled, and a final state clears the transient flags.
// With the table full and the id not in it, no slot is updated and no frame
// is emitted. Cancel walks the table once, giving a canceled item for each
// busy slot, and then clears it. in_stall is high for the whole event, so
// one item is taken at a time.
// A stalled output item holds, and the sequencer waits on it.
// Reset empties every slot, clears the frame count and drops out_valid.
// ----------------------------------------------------------------------------
module touch_contact_slot_tracker #(
    parameter int MAX_SLOTS = tcst_pkg::MAX_SLOTS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         action,
    input  logic [31:0]        finger_id,
    input  logic [16:0]        x_frac,
    input  logic [16:0]        y_frac,
    input  logic [10:0]        pressure_in,
    input  logic signed [15:0] rect_left,
    input  logic signed [15:0] rect_top,
    input  logic signed [15:0] rect_right,
    input  logic signed [15:0] rect_bottom,
    input  logic [8:0]         angle_in,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [31:0]        contact_id,
    output logic [5:0]         state_flags,
    output logic [15:0]        pos_x,
    output logic [15:0]        pos_y,
    output logic [10:0]        pressure_out,
    output logic [2:0]         valid_mask,
    output logic signed [15:0] area_left,
    output logic signed [15:0] area_top,
    output logic signed [15:0] area_right,
    output logic signed [15:0] area_bottom,
    output logic [8:0]         angle_out,
    output logic               last
);

    localparam int IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CW = $clog2(MAX_SLOTS + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(MAX_SLOTS - 1);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_SEARCH = 6'b000010,
        ST_UPDATE = 6'b000100,
        ST_EMIT   = 6'b001000,
        ST_CANCEL = 6'b010000,
        ST_DONE   = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    tcst_pkg::slot_t slot_reg [MAX_SLOTS];
    logic [MAX_SLOTS-1:0] busy;
    logic later_busy;
    logic [CW-1:0] frame_count_reg;
    logic [IW-1:0] idx_reg;
    logic [CW-1:0] idx_inc;
    logic hit_found_reg, empty_found_reg;
    logic [IW-1:0] hit_reg, empty_reg;
    logic [IW-1:0] sel;
    logic found;
    logic id_match;
    logic [1:0]   act_reg;
    logic [31:0]  id_reg;
    logic [15:0]  x_reg, y_reg;
    logic [10:0]  press_reg;
    logic [15:0]  rl_reg, rt_reg, rr_reg, rb_reg;
    logic [8:0]   ang_reg;
    tcst_pkg::slot_t cur, upd, out_reg, out_load_slot;
    logic out_valid_reg, out_last_reg;
    logic out_free, out_load, out_load_last;
    logic [5:0] f;

    assign cur = slot_reg[idx_reg];
    assign idx_inc = CW'(idx_reg) + CW'(1);
    assign sel = hit_found_reg ? hit_reg : empty_reg;
    assign found = hit_found_reg || empty_found_reg;
    assign id_match = busy[idx_reg] && (cur.id == id_reg);
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != ST_IDLE);

    // Cancel view of a slot: emitted as canceled
    function automatic tcst_pkg::slot_t cancel_view(input tcst_pkg::slot_t s);
        tcst_pkg::slot_t r;
        r = s;
        if (s.flags[tcst_pkg::FL_INCONTACT])
            r.flags[tcst_pkg::FL_UP] = 1'b1;
        else
            r.flags[tcst_pkg::FL_UPDATE] = 1'b1;
        r.flags[tcst_pkg::FL_INCONTACT] = 1'b0;
        r.flags[tcst_pkg::FL_INRANGE] = 1'b0;
        r.flags[tcst_pkg::FL_CANCELED] = 1'b1;
        r.mask = 3'd0;
        return r;
    endfunction

    always_comb
    begin
        for (int i = 0; i < MAX_SLOTS; i++)
            busy[i] = (slot_reg[i].flags != 6'd0);
    end

    always_comb
    begin
        later_busy = 1'b0;
        for (int i = 0; i < MAX_SLOTS; i++)
            if (i > int'(idx_reg))
                later_busy = later_busy | busy[i];
    end

    always_comb
    begin
        upd = slot_reg[sel];
        f = upd.flags;
        if (!hit_found_reg)
            upd.id = id_reg;
        if (act_reg == tcst_pkg::ACT_LIFT)
        begin
            f[tcst_pkg::FL_INCONTACT] = 1'b0;
            f[tcst_pkg::FL_INRANGE] = 1'b0;
            f[tcst_pkg::FL_UP] = 1'b1;
        end
        else
        begin
            f[tcst_pkg::FL_INCONTACT] = 1'b1;
            f[tcst_pkg::FL_INRANGE] = 1'b1;
            if (act_reg == tcst_pkg::ACT_DOWN)
                f[tcst_pkg::FL_DOWN] = 1'b1;
            else
                f[tcst_pkg::FL_UPDATE] = 1'b1;
            upd.x = x_reg;
            upd.y = y_reg;
        end
        upd.flags = f;
        upd.mask = 3'd0;
        if (f[tcst_pkg::FL_INCONTACT])
        begin
            if (press_reg != 11'd0)
            begin
                upd.mask[tcst_pkg::VM_PRESSURE] = 1'b1;
                upd.pressure = (press_reg > tcst_pkg::PRESS_MAX) ? tcst_pkg::PRESS_MAX
                                                                 : press_reg;
            end
            else
                upd.pressure = tcst_pkg::PRESS_DEFAULT;
            if (rl_reg != 16'd0 || rt_reg != 16'd0 || rr_reg != 16'd0 || rb_reg != 16'd0)
            begin
                upd.left = rl_reg;
                upd.top = rt_reg;
                upd.right = rr_reg;
                upd.bottom = rb_reg;
                upd.mask[tcst_pkg::VM_AREA] = 1'b1;
            end
        end
        else
        begin
            upd.pressure = 11'd0;
            upd.left = 16'd0;
            upd.top = 16'd0;
            upd.right = 16'd0;
            upd.bottom = 16'd0;
        end
        if (ang_reg < tcst_pkg::ANGLE_LIMIT)
        begin
            upd.mask[tcst_pkg::VM_ANGLE] = 1'b1;
            upd.angle = ang_reg;
        end
        else
            upd.angle = 9'd0;
    end

    always_comb
    begin
        out_load = 1'b0;
        out_load_last = 1'b0;
        out_load_slot = cur;
        if (state_reg == ST_EMIT && frame_count_reg != '0 && out_free)
        begin
            out_load = 1'b1;
            out_load_last = (idx_inc == frame_count_reg);
        end
        else if (state_reg == ST_CANCEL && busy[idx_reg] && out_free)
        begin
            out_load = 1'b1;
            out_load_last = !later_busy;
            out_load_slot = cancel_view(cur);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_valid)
                    state_next = (action == tcst_pkg::ACT_CANCEL) ? ST_CANCEL : ST_SEARCH;
            ST_SEARCH:
                if (idx_reg == LAST_IDX)
                    state_next = ST_UPDATE;
            ST_UPDATE:
                state_next = found ? ST_EMIT : ST_IDLE;
            ST_EMIT:
                if (frame_count_reg == '0 || (out_load && out_load_last))
                    state_next = ST_DONE;
            ST_CANCEL:
                if (idx_reg == LAST_IDX && (out_free || !busy[idx_reg]))
                    state_next = ST_DONE;
            ST_DONE:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            for (int i = 0; i < MAX_SLOTS; i++)
                slot_reg[i] <= '0;
            frame_count_reg <= '0;
            idx_reg <= '0;
            hit_found_reg <= 1'b0;
            empty_found_reg <= 1'b0;
            hit_reg <= '0;
            empty_reg <= '0;
            out_valid_reg <= 1'b0;
            out_last_reg <= 1'b0;
            out_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_load || (out_valid_reg && out_stall);
            if (out_load)
            begin
                out_reg <= out_load_slot;
                out_last_reg <= out_load_last;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    idx_reg <= '0;
                    hit_found_reg <= 1'b0;
                    empty_found_reg <= 1'b0;
                end
                ST_SEARCH:
                begin
                    if (!hit_found_reg && id_match)
                    begin
                        hit_found_reg <= 1'b1;
                        hit_reg <= idx_reg;
                    end
                    if (!empty_found_reg && !busy[idx_reg])
                    begin
                        empty_found_reg <= 1'b1;
                        empty_reg <= idx_reg;
                    end
                    idx_reg <= (idx_reg == LAST_IDX) ? '0 : idx_reg + IW'(1);
                end
                ST_UPDATE:
                    if (found)
                    begin
                        slot_reg[sel] <= upd;
                        if (!hit_found_reg)
                            frame_count_reg <= CW'(empty_reg) + CW'(1);
                    end
                ST_EMIT:
                    if (out_load)
                        idx_reg <= idx_reg + IW'(1);
                ST_CANCEL:
                    if (!busy[idx_reg] || out_free)
                        idx_reg <= (idx_reg == LAST_IDX) ? '0 : idx_reg + IW'(1);
                ST_DONE:
                    if (act_reg == tcst_pkg::ACT_CANCEL)
                    begin
                        for (int i = 0; i < MAX_SLOTS; i++)
                            slot_reg[i] <= '0;
                        frame_count_reg <= '0;
                    end
                    else
                        slot_reg[sel].flags <= {4'd0, slot_reg[sel].flags[1:0]};
                default:
                    ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid)
        begin
            act_reg <= action;
            id_reg <= finger_id;
            x_reg <= tcst_pkg::scale_frac(x_frac);
            y_reg <= tcst_pkg::scale_frac(y_frac);
            press_reg <= pressure_in;
            rl_reg <= rect_left;
            rt_reg <= rect_top;
            rr_reg <= rect_right;
            rb_reg <= rect_bottom;
            ang_reg <= angle_in;
        end
    end

    assign out_valid = out_valid_reg;
    assign contact_id = out_reg.id;
    assign state_flags = out_reg.flags;
    assign pos_x = out_reg.x;
    assign pos_y = out_reg.y;
    assign pressure_out = out_reg.pressure;
    assign valid_mask = out_reg.mask;
    assign area_left = out_reg.left;
    assign area_top = out_reg.top;
    assign area_right = out_reg.right;
    assign area_bottom = out_reg.bottom;
    assign angle_out = out_reg.angle;
    assign last = out_last_reg;

endmodule

@@ hdl/tcst_checker.sv @@
// ----------------------------------------------------------------------------
// tcst_checker
// Port-level checks on the touch contact slot tracker.
// ----------------------------------------------------------------------------
`include "touch_contact_slot_tracker_assert.svh"

module tcst_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [5:0]  state_flags,
    input logic [8:0]  angle_out,
    input logic [10:0] pressure_out
);

    `TCST_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall,
        "input not stalled after accepted item")
    `TCST_ASSERT_IMP(a_angle_range, clk, rst_n, out_valid, angle_out < 9'd360,
        "angle out of range")
    `TCST_ASSERT_IMP(a_press_range, clk, rst_n, out_valid, pressure_out <= 11'd1024,
        "pressure out of range")
    `TCST_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
        out_valid && $stable(state_flags) && $stable(angle_out) && $stable(pressure_out),
        "stalled output item changed")

endmodule

bind touch_contact_slot_tracker tcst_checker u_tcst_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .state_flags(state_flags),
    .angle_out(angle_out), .pressure_out(pressure_out)
);
